FILE: src/kdeq_pkg.sv
// Shared constants and types for the key debounce event queue.
package kdeq_pkg;

    // Default sizes handed down from the top level.
    localparam int NUM_KEYS_DEF    = 3;
    localparam int QUEUE_DEPTH_DEF = 16;

    // Field widths fixed by the item formats.
    localparam int TICK_W    = 32;
    localparam int CONFIRM_W = 16;
    localparam int CODE_W    = 8;
    localparam int CFG_W     = CONFIRM_W;

    // Register values after reset.
    localparam logic [CONFIRM_W-1:0] DEBOUNCE_MS_RST  = 16'd10;
    localparam logic [CODE_W-1:0]    RELEASE_FLAG_RST = 8'd128;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_DEBOUNCE_MS  = 1'b0,
        CFG_RELEASE_FLAG = 1'b1
    } cfg_index_t;

endpackage

FILE: src/kdeq_scan_if.sv
// Request channels of the key debounce event queue: key scans in and events out.
interface kdeq_scan_if #(
    parameter int NumKeys = kdeq_pkg::NUM_KEYS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [NumKeys-1:0]           pin_levels;
    logic [kdeq_pkg::TICK_W-1:0]  tick;

    modport source (output valid, output pin_levels, output tick, input ready);
    modport sink   (input valid, input pin_levels, input tick, output ready);
endinterface

interface kdeq_event_if;
    logic                         valid;
    logic                         ready;
    logic                         event_valid;
    logic [kdeq_pkg::CODE_W-1:0]  event_code;

    modport source (output valid, output event_valid, output event_code, input ready);
    modport sink   (input valid, input event_valid, input event_code, output ready);
endinterface

FILE: src/kdeq_key_fsm.sv
// Debounce state machine for one key: idle, confirm and pressed phases.
module kdeq_key_fsm (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  logic                              down,
    input  logic [kdeq_pkg::TICK_W-1:0]       tick,
    input  logic [kdeq_pkg::CONFIRM_W-1:0]    debounce_ms,
    output logic                              release_req
);
    import kdeq_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_CONFIRM = 3'b010,
        PH_PRESSED = 3'b100
    } phase_t;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [TICK_W-1:0]  stamp_reg;
    logic [TICK_W-1:0]  held_time;
    logic               confirmed;

    // Wrapping difference; the register is zero-extended to the tick width.
    assign held_time = tick - stamp_reg;
    assign confirmed = held_time >= {{(TICK_W-CONFIRM_W){1'b0}}, debounce_ms};

    assign release_req = (phase_reg == PH_PRESSED) && !down;

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (down)
                    phase_next = PH_CONFIRM;
            end
            PH_CONFIRM:
            begin
                if (!down)
                    phase_next = PH_IDLE;
                else if (confirmed)
                    phase_next = PH_PRESSED;
            end
            PH_PRESSED:
            begin
                if (!down)
                    phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_IDLE;
        else if (step)
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        if (step && (phase_reg == PH_IDLE) && down)
            stamp_reg <= tick;
    end

    // A key can only become armed from the confirm phase.
    a_pressed_from_confirm: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(phase_reg == PH_PRESSED) |-> $past(phase_reg) == PH_CONFIRM)
        else $error("key armed without passing through confirm");

endmodule

FILE: src/kdeq_event_queue.sv
// Event queue: accepts the release codes of one scan in key order, then pops one.
module kdeq_event_queue #(
    parameter int NumKeys    = kdeq_pkg::NUM_KEYS_DEF,
    parameter int QueueDepth = kdeq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [NumKeys-1:0]            release_req,
    input  logic [kdeq_pkg::CODE_W-1:0]   release_flag,
    output logic                          pop_valid,
    output logic [kdeq_pkg::CODE_W-1:0]   pop_code
);
    import kdeq_pkg::*;

    localparam int PTR_W = $clog2(QueueDepth);
    localparam int CNT_W = $clog2(QueueDepth + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QueueDepth - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QueueDepth);

    logic [CODE_W-1:0] store_reg [QueueDepth];
    logic [PTR_W-1:0]  head_reg;
    logic [PTR_W-1:0]  head_next;
    logic [PTR_W-1:0]  tail_reg;
    logic [PTR_W-1:0]  tail_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic              wr_en   [NumKeys];
    logic [PTR_W-1:0]  wr_addr [NumKeys];
    logic [CODE_W-1:0] wr_data [NumKeys];

    // Pushes are placed in key order; each accepted one takes the next free slot.
    always_comb
    begin
        logic [CNT_W-1:0]  cnt;
        logic [PTR_W-1:0]  tl;
        logic              have_first;
        logic [CODE_W-1:0] first_code;

        cnt        = count_reg;
        tl         = tail_reg;
        have_first = 1'b0;
        first_code = '0;
        for (int j = 0; j < NumKeys; j++)
        begin
            wr_en[j]   = 1'b0;
            wr_addr[j] = tl;
            wr_data[j] = CODE_W'(j) | release_flag;
            if (release_req[j] && (cnt < FULL_CNT))
            begin
                wr_en[j] = 1'b1;
                if (!have_first)
                    first_code = wr_data[j];
                have_first = 1'b1;
                tl  = (tl == LAST_PTR) ? '0 : tl + 1'b1;
                cnt = cnt + 1'b1;
            end
        end
        tail_next = tl;

        // An empty queue hands out the first code pushed in the same scan.
        pop_valid = (cnt != '0);
        if (!pop_valid)
            pop_code = '0;
        else if (count_reg == '0)
            pop_code = first_code;
        else
            pop_code = store_reg[head_reg];

        count_next = pop_valid ? cnt - 1'b1 : cnt;
        if (pop_valid)
            head_next = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
        else
            head_next = head_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (step)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NumKeys; j++)
        begin
            if (step && wr_en[j])
                store_reg[wr_addr[j]] <= wr_data[j];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue fill count exceeds depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == FULL_CNT) |-> head_reg == tail_reg)
        else $error("pointers disagree with empty or full queue");

    a_pop_source: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && count_reg == '0) |-> (release_req != '0))
        else $error("pop from empty queue without a push");

endmodule

FILE: src/key_debounce_event_queue_core.sv
// Top level of the key debounce event queue: scan register, key machines, queue, result register.
//
// Use: every request on the scan channel carries the raw active-low key levels
// (pin_levels, bit i for key i) and the current millisecond tick. Each key runs
// an idle, confirm and pressed machine; a press held for at least the debounce
// time in milliseconds arms the key, and its release queues the code (key index
// OR release_flag). Keys are handled in index order, then one code is popped.
// Every scan request yields exactly one event request: event_valid is 1 with the
// popped code, or 0 with a zero code when the queue was empty. A release onto a
// full queue is dropped.
// A scan is captured in the input register when it is accepted; the key
// machines and the queue are updated from it when it advances, and the event
// is stored in the result register, which offers the event request. Throughput
// is one scan per cycle while the event receiver does not stall; all per-key
// updates and the single queue access fit between those two registers.
// When the event receiver stalls, the result register holds its request and the
// input register can still take one more scan; only then does scan.ready drop.
// Reset puts all keys in idle, empties the queue and loads a debounce time of
// 10 ms and a release flag of 128. Configuration writes take effect on the next
// edge and are meant to be issued only while no scan is in flight.
module key_debounce_event_queue_core #(
    parameter int NUM_KEYS    = kdeq_pkg::NUM_KEYS_DEF,
    parameter int QUEUE_DEPTH = kdeq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    kdeq_scan_if.sink                        scan,
    kdeq_event_if.source                     evt,
    input  logic                             cfg_we,
    input  kdeq_pkg::cfg_index_t             cfg_index,
    input  logic [kdeq_pkg::CFG_W-1:0]       cfg_wdata
);
    import kdeq_pkg::*;

    // Configuration registers.
    logic [CONFIRM_W-1:0] debounce_ms_reg;
    logic [CODE_W-1:0]    release_flag_reg;

    // Input register holding one scan request.
    logic                 s1_valid_reg;
    logic [NUM_KEYS-1:0]  s1_levels_reg;
    logic [TICK_W-1:0]    s1_tick_reg;

    // Result register holding one event request.
    logic                 out_valid_reg;
    logic                 out_event_valid_reg;
    logic [CODE_W-1:0]    out_event_code_reg;

    logic                 advance;
    logic [NUM_KEYS-1:0]  release_req;
    logic                 pop_valid;
    logic [CODE_W-1:0]    pop_code;

    // The scan in the input register is processed whenever the result register
    // is free or is being emptied in this cycle.
    assign advance    = s1_valid_reg && (!out_valid_reg || evt.ready);
    assign scan.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg  <= DEBOUNCE_MS_RST;
            release_flag_reg <= RELEASE_FLAG_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE_MS:  debounce_ms_reg  <= cfg_wdata[CONFIRM_W-1:0];
                CFG_RELEASE_FLAG: release_flag_reg <= cfg_wdata[CODE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (scan.ready)
            s1_valid_reg <= scan.valid;
    end

    always_ff @(posedge clk)
    begin
        if (scan.valid && scan.ready)
        begin
            s1_levels_reg <= scan.pin_levels;
            s1_tick_reg   <= scan.tick;
        end
    end

    // One debounce machine per key; a low level means the key is down.
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        kdeq_key_fsm u_key (
            .clk          (clk),
            .rst_n        (rst_n),
            .step         (advance),
            .down         (!s1_levels_reg[k]),
            .tick         (s1_tick_reg),
            .debounce_ms  (debounce_ms_reg),
            .release_req  (release_req[k])
        );
    end

    kdeq_event_queue #(
        .NumKeys    (NUM_KEYS),
        .QueueDepth (QUEUE_DEPTH)
    ) u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .release_req  (release_req),
        .release_flag (release_flag_reg),
        .pop_valid    (pop_valid),
        .pop_code     (pop_code)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (evt.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_event_valid_reg <= pop_valid;
            out_event_code_reg  <= pop_code;
        end
    end

    assign evt.valid       = out_valid_reg;
    assign evt.event_valid = out_event_valid_reg;
    assign evt.event_code  = out_event_code_reg;

    // A scan stuck behind a stalled result must not be lost or altered.
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_tick_reg)))
        else $error("pending scan changed while stalled");

    // Every processed scan produces a result request on the next edge.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed scan produced no result");

    // An empty pop always carries a zero code.
    a_empty_code: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !pop_valid) |=> (out_event_code_reg == '0))
        else $error("empty pop carried a nonzero code");

endmodule
